// File: hdl/ndcg_pkg.sv
// Package for the nDCG-at-cutoffs core: action codes, register indexes and formats.
// No dependencies.
package ndcg_pkg;

	localparam int DISC_BITS = 15;
	localparam int DCG_W     = 40;
	localparam int OUT_W     = 32;
	localparam int CFG_W     = 11;

	typedef enum logic [1:0] {
		ACT_DOC    = 2'd0,
		ACT_COUNT  = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic [2:0] REG_CUT_A = 3'd0;
	localparam logic [2:0] REG_IN_USE = 3'd6;

endpackage

// File: hdl/ndcg_at_cutoffs_core.sv
// nDCG at up to six cutoffs, exponential gain, Q16.16 output.
// Depends on ndcg_pkg and ndcg_ram (discount table, filled after reset).
//
// channel   dir  beat contents
// s_axis    in   tdata: action, doc_level, level_number, level_total
// m_axis    out  tdata: cutoff_number, ndcg_value; tlast: last_value
// cfg       in   we / idx / data, no read-back
//
// Doc beats that add a term pass a table read and an accumulate state (S_DREAD,
// S_DACC); other beats are taken in S_IDLE. Finish: fill of uncaptured slots,
// ideal walk of up to MAX_RANK steps (a level test, a read and an accumulate
// each, plus a level step per level skipped), ideal fill, then per cutoff a
// setup state, a 56-step shared restoring divider, a load step and one output
// beat (setup and beat only when the ideal DCG is zero). After reset each of the
// MAX_RANK discount entries is computed (30 squarings, 16 divide steps) and written, tready low.
// Output stalls hold the sequencer.
module ndcg_at_cutoffs_core #(
	parameter int MAX_RANK    = 1024,
	parameter int MAX_CUTOFFS = 6,
	parameter int LEVEL_COUNT = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // action[1:0] doc_level[5:2] level_number[8:6] level_total[24:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // cutoff_number[2:0] ndcg_value[34:3]
	output logic        m_axis_tlast,  // last_value
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [10:0] cfg_data
);
	localparam int RW = $clog2(MAX_RANK);
	localparam int CW = $clog2(MAX_RANK + 1);
	localparam int NB = $clog2(MAX_RANK + 2);
	localparam int LW = $clog2(LEVEL_COUNT);
	localparam int DW = ndcg_pkg::DCG_W;
	localparam int NW = DW + FRAC_BITS;
	localparam logic [DW-1:0] DMAX = '1;

	typedef enum logic [3:0] {
		S_INIT, S_LOG, S_LDIV, S_IDIV, S_IWR,
		S_IDLE, S_DREAD, S_DACC, S_FILL, S_WLVL, S_WREAD, S_WACC,
		S_IFILL, S_DIVST, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [10:0] cut_q [6];
	logic [2:0]  inuse_q;
	logic [CW-1:0] rank_q;
	logic [DW-1:0] run_q, ideal_q;
	logic [DW-1:0] dcg_q [MAX_CUTOFFS];
	logic [DW-1:0] ida_q [MAX_CUTOFFS];
	logic [2:0]  slot_q;
	logic [15:0] cnt_q [LEVEL_COUNT];
	logic [LW-1:0] lvl_q;
	logic [16:0] wc_q;
	logic [3:0]  lv_q;
	logic [RW-1:0] ia_q;
	logic [NW-1:0] num_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [6:0]    step_q;
	logic [31:0]   oval_q;
	logic [2:0]    k_q;
	logic [30:0]   y_q;
	logic [4:0]    ip_q;
	logic [29:0]   fr_q;

	logic [15:0] rd;
	logic [RW-1:0] raddr;
	logic [2:0] n;
	logic [DW-1:0] term, sum_s;
	logic [DW:0] sum_w, sh, sub;
	logic [DW-1:0] dsh;
	logic [DW-1:0] cdcg, cid, dvs;
	logic [NB-1:0] nv;
	logic [4:0]    ipc;
	logic [NB+29:0] nsh;
	logic [61:0]   sq;
	logic [34:0]   lq;
	logic [45:0]   nden;
	logic [DW:0]   rem0;

	always_comb begin
		n = inuse_q;
		if (inuse_q == 3'd0) n = 3'd1;
		if (32'(inuse_q) > MAX_CUTOFFS) n = 3'(MAX_CUTOFFS);
	end

	// discount entry D(r) = round(2^45 / log2(r+1) in Q.30), r = ia_q + 1
	always_comb begin
		nv = NB'(ia_q) + NB'(2);
		ipc = '0;
		for (int i = 0; i < NB; i++) begin
			if (nv[i]) ipc = 5'(i);
		end
		nsh = {nv, 30'd0} >> ipc;
		sq = 62'(y_q) * 62'(y_q);
		lq = {ip_q, fr_q};
		nden = {1'b1, 45'd0} + 46'(lq >> 1);
		rem0 = {{(DW-29){1'b0}}, nden[45:16]};
	end

	assign raddr = (state_q == S_INIT) ? ia_q : rank_q[RW-1:0];

	ndcg_ram #(.WIDTH(16), .DEPTH(MAX_RANK)) u_disc (
		.clk(clk), .we(state_q == S_IWR), .waddr(ia_q),
		.wdata(quo_q[15:0]), .raddr(raddr), .rdata(rd)
	);

	// shared shift/accumulate: doc terms and ideal terms
	always_comb begin
		if (state_q == S_WACC) begin
			term = DW'(rd) << lvl_q;
		end else if (lv_q[3]) begin
			term = DW'(rd) >> (5'd16 - 5'(lv_q));
		end else begin
			term = DW'(rd) << lv_q[2:0];
		end
		sum_w = {1'b0, (state_q == S_WACC) ? ideal_q : run_q} + {1'b0, term};
		sum_s = sum_w[DW] ? DMAX : sum_w[DW-1:0];
	end

	assign cdcg = dcg_q[k_q];
	assign cid  = ida_q[k_q];
	assign dvs = (state_q == S_IDIV) ? DW'(lq) : cid;
	assign sh  = {rem_q[DW-1:0], num_q[NW-1]};
	assign sub = sh - {1'b0, dvs};
	localparam int SHR = (FRAC_BITS >= ndcg_pkg::DISC_BITS) ? 0
		: ndcg_pkg::DISC_BITS - FRAC_BITS;
	localparam int SHL = (FRAC_BITS >= ndcg_pkg::DISC_BITS)
		? FRAC_BITS - ndcg_pkg::DISC_BITS : 0;
	assign dsh = (cdcg << SHL) >> SHR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cut_q[0] <= 11'd5; cut_q[1] <= 11'd10; cut_q[2] <= 11'd15;
			cut_q[3] <= 11'd20; cut_q[4] <= 11'd30; cut_q[5] <= 11'd100;
			inuse_q <= 3'd6;
			rank_q <= '0;
			run_q <= '0;
			ideal_q <= '0;
			slot_q <= '0;
			ia_q <= '0;
			k_q <= '0;
			lvl_q <= '0;
			wc_q <= '0;
			step_q <= '0;
			y_q <= '0;
			ip_q <= '0;
			fr_q <= '0;
			for (int i = 0; i < MAX_CUTOFFS; i++) begin
				dcg_q[i] <= '0;
				ida_q[i] <= '0;
			end
			for (int i = 0; i < LEVEL_COUNT; i++) cnt_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx < ndcg_pkg::REG_IN_USE) cut_q[cfg_idx] <= cfg_data;
				else if (cfg_idx == ndcg_pkg::REG_IN_USE) inuse_q <= cfg_data[2:0];
			end
			case (state_q)
				S_INIT: begin
					y_q <= nsh[30:0];
					ip_q <= ipc;
					fr_q <= '0;
					step_q <= '0;
					state_q <= S_LOG;
				end
				S_LOG: begin
					if (sq[61]) y_q <= sq[61:31];
					else y_q <= sq[60:30];
					fr_q <= {fr_q[28:0], sq[61]};
					step_q <= step_q + 1'b1;
					if (step_q == 7'd29) state_q <= S_LDIV;
				end
				S_LDIV: begin
					rem_q <= rem0;
					num_q <= {nden[15:0], {(NW-16){1'b0}}};
					quo_q <= '0;
					step_q <= '0;
					state_q <= S_IDIV;
				end
				S_IWR: begin
					ia_q <= ia_q + 1'b1;
					if (ia_q == RW'(MAX_RANK - 1)) state_q <= S_IDLE;
					else state_q <= S_INIT;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						lv_q <= s_axis_tdata[5:2];
						case (ndcg_pkg::action_t'(s_axis_tdata[1:0]))
							ndcg_pkg::ACT_DOC: begin
								if (rank_q < CW'(MAX_RANK) && slot_q < n) begin
									if (11'(rank_q) == cut_q[slot_q] && rank_q <= 11'h7FF) begin
										dcg_q[slot_q] <= run_q;
										slot_q <= slot_q + 1'b1;
										if (slot_q + 1'b1 < n) state_q <= S_DREAD;
									end else begin
										state_q <= S_DREAD;
									end
								end
							end
							ndcg_pkg::ACT_COUNT: begin
								if (32'(s_axis_tdata[8:6]) < LEVEL_COUNT)
									cnt_q[LW'(s_axis_tdata[8:6])] <= s_axis_tdata[24:9];
							end
							ndcg_pkg::ACT_FINISH: begin
								state_q <= S_FILL;
								k_q <= slot_q;
							end
							default: ;
						endcase
					end
				end
				S_DREAD: state_q <= S_DACC;
				S_DACC: begin
					run_q <= sum_s;
					rank_q <= rank_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL: begin
					if (k_q < n) begin
						dcg_q[k_q] <= run_q;
						k_q <= k_q + 1'b1;
					end else begin
						rank_q <= '0;
						slot_q <= '0;
						ideal_q <= '0;
						lvl_q <= LW'(LEVEL_COUNT - 1);
						wc_q <= 17'd1;
						state_q <= S_WLVL;
					end
				end
				S_WLVL: begin
					// one level step per cycle, then test cutoff
					if (lvl_q != '0 && wc_q > 17'(cnt_q[lvl_q])) begin
						lvl_q <= lvl_q - 1'b1;
						wc_q <= 17'd1;
					end else if (lvl_q == '0) begin
						k_q <= slot_q;
						state_q <= S_IFILL;
					end else if (11'(rank_q) == cut_q[slot_q] && rank_q <= 11'h7FF) begin
						ida_q[slot_q] <= ideal_q;
						slot_q <= slot_q + 1'b1;
						if (slot_q + 1'b1 >= n) begin
							k_q <= slot_q + 1'b1;
							state_q <= S_IFILL;
						end else state_q <= S_WREAD;
					end else state_q <= S_WREAD;
				end
				S_WREAD: state_q <= S_WACC;
				S_WACC: begin
					ideal_q <= sum_s;
					rank_q <= rank_q + 1'b1;
					wc_q <= wc_q + 1'b1;
					if (rank_q + 1'b1 >= CW'(MAX_RANK)) begin
						k_q <= slot_q;
						state_q <= S_IFILL;
					end else state_q <= S_WLVL;
				end
				S_IFILL: begin
					if (k_q < n) begin
						ida_q[k_q] <= ideal_q;
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						state_q <= S_DIVST;
					end
				end
				S_DIVST: begin
					num_q <= NW'(cdcg) << FRAC_BITS;
					rem_q <= '0;
					quo_q <= '0;
					step_q <= '0;
					if (cid == '0) begin
						oval_q <= (|(dsh >> 32)) ? '1 : dsh[31:0];
						state_q <= S_OUT;
					end else state_q <= S_DIV;
				end
				S_DIV, S_IDIV: begin
					num_q <= num_q << 1;
					if (!sub[DW]) begin
						rem_q <= sub;
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= sh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (state_q == S_IDIV) begin
						if (step_q == 7'd15) state_q <= S_IWR;
					end else if (step_q == 7'(NW - 1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (step_q != '0) begin
						oval_q <= (|(quo_q >> 32)) ? '1 : quo_q[31:0];
						step_q <= '0;
					end else if (m_axis_tready) begin
						if (k_q + 1'b1 >= n) begin
							rank_q <= '0;
							run_q <= '0;
							slot_q <= '0;
							for (int i = 0; i < LEVEL_COUNT; i++) cnt_q[i] <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_DIVST;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT) && (step_q == '0);
	assign m_axis_tdata  = {5'd0, oval_q, k_q};
	assign m_axis_tlast  = (k_q + 1'b1 >= n);
endmodule

// File: hdl/ndcg_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module ndcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/ndcg_checker.sv
// Port-level checks for ndcg_at_cutoffs_core, bound into every instance of the core.
// Binds into ndcg_at_cutoffs_core; no other dependencies.
module ndcg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in ready during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("beat after last");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("input reopened mid-frame");
endmodule

bind ndcg_at_cutoffs_core ndcg_checker u_chk (.*);

// File: tb/tb_top.sv
// Testbench for ndcg_at_cutoffs_core: stream stimulus, an in-bench nDCG predictor,
// and a scoreboard on the result stream. Depends on ndcg_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;

	localparam int RANKS = 1024;
	localparam int NCUT  = 6;
	localparam int NLVL  = 8;
	localparam longint unsigned DCG_SAT = (64'd1 << 40) - 1;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]  cut_no;
		logic [31:0] value;
		logic        last;
	} ndcg_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [10:0] cfg_data;

	ndcg_at_cutoffs_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [10:0]     cut_reg [NCUT];
	logic [2:0]      cuts_used_reg;
	int unsigned     doc_rank;
	longint unsigned dcg_run;
	longint unsigned dcg_cap [NCUT];
	int unsigned     cap_slot;
	logic [15:0]     judged [NLVL];
	logic [15:0]     discount [RANKS];

	ndcg_res_t ndcg_q[$];
	int errors;
	int idle_cycles;
	int src_gap_max;
	int snk_gap_max;
	int hold_off;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned lg2_fix30(input int unsigned n);
		int unsigned ip;
		longint unsigned y, fr;
		ip = 0;
		fr = 0;
		while ((n >> ip) > 1) ip++;
		y = (longint'(n) << 30) >> ip;
		for (int b = 29; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				fr = fr | (64'd1 << b);
			end
		end
		return (longint'(ip) << 30) | fr;
	endfunction

	function automatic longint unsigned sat40(input longint unsigned a, input longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > DCG_SAT) ? DCG_SAT : s;
	endfunction

	function automatic int unsigned cuts_eff();
		int unsigned n;
		n = cuts_used_reg;
		if (n == 0) n = 1;
		if (n > NCUT) n = NCUT;
		return n;
	endfunction

	function automatic logic [31:0] q16_ratio(input longint unsigned g, input longint unsigned ig);
		longint unsigned v;
		if (ig != 0) v = (g << 16) / ig;
		else v = g << 1;
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	task automatic clear_topic();
		doc_rank = 0;
		dcg_run = 0;
		cap_slot = 0;
		for (int i = 0; i < NLVL; i++) judged[i] = '0;
	endtask

	task automatic predict_beat(input logic [31:0] d);
		ndcg_pkg::action_t a;
		int lv;
		int unsigned n, slot, lvl, cnt;
		longint unsigned term, ideal;
		longint unsigned ideal_cap [NCUT];
		ndcg_res_t r;
		a = ndcg_pkg::action_t'(d[1:0]);
		lv = $signed(d[5:2]);
		n = cuts_eff();
		case (a)
			ndcg_pkg::ACT_DOC: begin
				if (doc_rank >= RANKS || cap_slot >= n) return;
				if (doc_rank == cut_reg[cap_slot]) begin
					dcg_cap[cap_slot] = dcg_run;
					cap_slot++;
					if (cap_slot >= n) return;
				end
				term = (lv >= 0) ? (longint'(discount[doc_rank]) << lv)
					: (longint'(discount[doc_rank]) >> (-lv));
				dcg_run = sat40(dcg_run, term);
				doc_rank++;
			end
			ndcg_pkg::ACT_COUNT: judged[d[8:6]] = d[24:9];
			ndcg_pkg::ACT_FINISH: begin
				for (int k = cap_slot; k < n; k++) dcg_cap[k] = dcg_run;
				ideal = 0;
				slot = 0;
				lvl = NLVL - 1;
				cnt = 0;
				for (int i = 0; i < RANKS; i++) begin
					cnt++;
					while (lvl > 0 && cnt > judged[lvl]) begin
						lvl--;
						cnt = 1;
					end
					if (lvl == 0) break;
					if (i == cut_reg[slot]) begin
						ideal_cap[slot] = ideal;
						slot++;
						if (slot >= n) break;
					end
					ideal = sat40(ideal, longint'(discount[i]) << lvl);
				end
				for (int k = slot; k < n; k++) ideal_cap[k] = ideal;
				for (int k = 0; k < n; k++) begin
					r.cut_no = k[2:0];
					r.value = q16_ratio(dcg_cap[k], ideal_cap[k]);
					r.last = (k + 1 == n);
					ndcg_q.push_back(r);
				end
				clear_topic();
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// watchdog on stalled handshakes
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// scoreboard
	always @(posedge clk) begin
		ndcg_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (ndcg_q.size() == 0) begin
				report("unexpected beat", m_axis_tdata[34:3], '0);
			end else begin
				e = ndcg_q.pop_front();
				if (m_axis_tdata[2:0] !== e.cut_no)
					report("cutoff_number", 32'(m_axis_tdata[2:0]), 32'(e.cut_no));
				if (m_axis_tdata[34:3] !== e.value)
					report("ndcg_value", m_axis_tdata[34:3], e.value);
				if (m_axis_tlast !== e.last)
					report("last_value", 32'(m_axis_tlast), 32'(e.last));
			end
		end
	end

	// result-side ready with random gaps and an optional long hold-off
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			g = (snk_gap_max > 0) ? $urandom_range(0, snk_gap_max) : 0;
			if (g > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_beat(input ndcg_pkg::action_t a, input int lv, input int ln, input int tot);
		int g;
		logic [31:0] d;
		d = {7'd0, tot[15:0], ln[2:0], lv[3:0], a};
		g = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
		if (g > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		predict_beat(d);
	endtask

	task automatic wait_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (ndcg_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == ndcg_pkg::REG_IN_USE) cuts_used_reg = val[2:0];
		else cut_reg[idx] = val;
	endtask

	task automatic set_cutoffs(input int c0, c1, c2, c3, c4, c5, input int used);
		int c [NCUT];
		c = '{c0, c1, c2, c3, c4, c5};
		wait_results();
		for (int i = 0; i < NCUT; i++) write_reg(ndcg_pkg::REG_CUT_A + 3'(i), 11'(c[i]));
		write_reg(ndcg_pkg::REG_IN_USE, {8'($urandom_range(0, 255)), used[2:0]});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_level();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return $urandom_range(0, 7) - 8;
		return $urandom_range(0, 9) - 2;
	endfunction

	task automatic random_topic(input int max_docs);
		int nd;
		for (int l = 0; l < NLVL; l++)
			if ($urandom_range(0, 2) != 0)
				send_beat(ndcg_pkg::ACT_COUNT, 0, l, ($urandom_range(0, 19) == 0)
					? $urandom_range(0, 65535) : $urandom_range(0, 12));
		nd = $urandom_range(0, max_docs);
		for (int i = 0; i < nd; i++) begin
			if ($urandom_range(0, 29) == 0)
				send_beat(ndcg_pkg::ACT_NONE, $urandom, $urandom, $urandom);
			else if ($urandom_range(0, 19) == 0)
				send_beat(ndcg_pkg::ACT_COUNT, 0, $urandom, $urandom);
			else send_beat(ndcg_pkg::ACT_DOC, rand_level(), $urandom, $urandom);
		end
		send_beat(ndcg_pkg::ACT_FINISH, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		send_beat(ndcg_pkg::ACT_COUNT, 0, 7, 2);
		send_beat(ndcg_pkg::ACT_COUNT, 0, 3, 65535);
		send_beat(ndcg_pkg::ACT_COUNT, 0, 0, 9);
		send_beat(ndcg_pkg::ACT_COUNT, 0, 1, 1);
		for (int lv = -8; lv <= 7; lv++) send_beat(ndcg_pkg::ACT_DOC, lv, 7, 65535);
		send_beat(ndcg_pkg::ACT_NONE, 7, 7, 65535);
		send_beat(ndcg_pkg::ACT_DOC, 7, 0, 0);
		send_beat(ndcg_pkg::ACT_FINISH, 0, 0, 0);
		send_beat(ndcg_pkg::ACT_FINISH, 0, 0, 0);
	endtask

	task automatic test_rank_limit();
		set_cutoffs(1, 2, 1000, 1023, 1024, 2047, 6);
		send_beat(ndcg_pkg::ACT_COUNT, 0, 7, 65535);
		for (int i = 0; i < 40; i++) send_beat(ndcg_pkg::ACT_DOC, 7, 0, 0);
		send_beat(ndcg_pkg::ACT_FINISH, 0, 0, 0);
	endtask

	task automatic test_settings();
		set_cutoffs(3, 1, 1, 7, 2, 0, 0);
		repeat (2) random_topic(12);
		set_cutoffs(1, 2, 3, 4, 5, 6, 7);
		repeat (2) random_topic(12);
		set_cutoffs(2047, 2047, 2047, 2047, 2047, 2047, 6);
		repeat (2) random_topic(10);
		set_cutoffs(4, 4, 9, 9, 12, 40, 5);
		repeat (2) random_topic(16);
		set_cutoffs(0, 5, 10, 15, 20, 30, 1);
		repeat (2) random_topic(10);
	endtask

	task automatic test_random();
		int a [NCUT];
		for (int p = 0; p < 4; p++) begin
			a[0] = $urandom_range(1, 4);
			for (int i = 1; i < NCUT; i++) a[i] = a[i - 1] + $urandom_range(0, 6);
			set_cutoffs(a[0], a[1], a[2], a[3], a[4], a[5], $urandom_range(1, 6));
			src_gap_max = (p == 2) ? 0 : 13;
			snk_gap_max = (p == 3) ? 0 : 13;
			repeat (2) random_topic(20);
		end
		src_gap_max = 13;
		snk_gap_max = 13;
	endtask

	task automatic test_pressure();
		set_cutoffs(1, 2, 3, 4, 5, 6, 6);
		src_gap_max = 0;
		hold_off = 400;
		repeat (6) begin
			send_beat(ndcg_pkg::ACT_COUNT, 0, 2, 3);
			send_beat(ndcg_pkg::ACT_DOC, 2, 0, 0);
			send_beat(ndcg_pkg::ACT_FINISH, 0, 0, 0);
		end
		src_gap_max = 13;
		wait_results();
		random_topic(10);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		src_gap_max = 13;
		snk_gap_max = 13;
		cut_reg = '{11'd5, 11'd10, 11'd15, 11'd20, 11'd30, 11'd100};
		cuts_used_reg = 3'd6;
		for (int i = 0; i < NCUT; i++) dcg_cap[i] = 0;
		for (int r = 0; r < RANKS; r++) begin
			longint unsigned l;
			l = lg2_fix30(r + 2);
			discount[r] = 16'(((64'd1 << 45) + l / 2) / l);
		end
		clear_topic();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_pressure();
		test_settings();
		test_random();
		test_rank_limit();

		wait_results();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/ndcg_pkg.sv
hdl/ndcg_ram.sv
hdl/ndcg_at_cutoffs_core.sv
hdl/ndcg_checker.sv
tb/tb_top.sv
